@@ design/scu_pkg.sv @@
// Shared constants for the stack calculator: command codes, limits and widths.
package scu_pkg;

    localparam int DEF_STACK_DEPTH = 1024;

    localparam int CMD_W   = 4;
    localparam int VAL_W   = 31;
    localparam int DOUT_W  = 11;
    localparam int RES_W   = 64;

    localparam logic [CMD_W-1:0] CMD_START = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_NEG   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DUP   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_MOD   = 4'd10;

    localparam logic signed [RES_W-1:0] MAG_LIMIT = 64'sd1000000000;

endpackage

@@ design/scu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scu_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/stack_calculator_with_error_checks_unit.sv @@
// Top level of the integer stack calculator with sticky error checking.
//
// Usage: one instruction beat on the input channel (i_valid / o_stall, command
// and operand) gives exactly one result beat on the output channel
// (o_valid / i_stall, error flag, depth, top value, answer valid).
// The stack lives in a single synchronous RAM; the top entry is mirrored in a
// register. Instructions run one at a time through a small sequencer:
//   start, push, dup and failing checks   : straight to the finish
//   pop, negate                           : pop re-reads the new top entry
//                                           when entries remain; negate is
//                                           range-checked
//   swap, add, sub, mul                   : read the entry below the top
//   operands consumed on an error         : top entry re-read
//   div and mod                           : also run the radix-2 divider
//                                           (31 quotient bits)
// Because the RAM read data is registered, the entry below the top is fetched
// in a state of its own whenever it is needed. No read whose data is used
// overlaps a write, so no forwarding is required.
// Reset clears the depth, the error flag and both handshakes; the RAM needs no
// clearing since entries are only read below the depth.
// A result waits in an output register while i_stall is high; the next
// instruction is still taken and runs up to its finish, where it holds until
// the output register frees.
module stack_calculator_with_error_checks_unit #(
    parameter int STACK_DEPTH = scu_pkg::DEF_STACK_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [scu_pkg::CMD_W-1:0]         i_command,
    input  logic signed [scu_pkg::VAL_W-1:0]  i_operand_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_error_seen,
    output logic [scu_pkg::DOUT_W-1:0]        o_stack_depth,
    output logic signed [scu_pkg::VAL_W-1:0]  o_top_value,
    output logic                              o_answer_valid
);
    import scu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_LRD   = 4'd2;
    localparam logic [3:0] S_SWP   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_DFIX  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_TOPRD = 4'd7;
    localparam logic [3:0] S_TOPLD = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]              r_state, n_state;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [DW-1:0]           r_depth, n_depth;
    logic                    r_err, n_err;
    logic signed [VAL_W-1:0] r_top, n_top;
    logic signed [VAL_W-1:0] r_left, n_left;
    logic signed [RES_W-1:0] r_res, n_res;
    logic [VAL_W-1:0]        r_rem, n_rem;
    logic [VAL_W-1:0]        r_quo, n_quo;
    logic [VAL_W-1:0]        r_dvs, n_dvs;
    logic [4:0]              r_cnt, n_cnt;
    logic                    r_neg_q, n_neg_q;
    logic                    r_neg_l, n_neg_l;
    logic                    r_o_valid, n_o_valid;
    logic                    r_o_err, n_o_err;
    logic [DOUT_W-1:0]       r_o_depth, n_o_depth;
    logic signed [VAL_W-1:0] r_o_top, n_o_top;
    logic                    r_o_ans, n_o_ans;

    logic                    w_we;
    logic [AW-1:0]           w_waddr, w_raddr;
    logic [VAL_W-1:0]        w_wdata, w_ram_q;
    logic signed [VAL_W-1:0] w_rdata;
    logic [DW-1:0]           w_dm1, w_dm2;
    logic                    w_full, w_empty, w_bad;
    logic signed [61:0]      w_prod;
    logic [VAL_W-1:0]        w_abs_l, w_abs_r;
    logic [VAL_W:0]          w_rem_sh, w_rem_sub;
    logic [DW+DOUT_W-1:0]    w_depth_ext;

    scu_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign w_rdata   = w_ram_q;
    assign w_dm1     = r_depth - DW'(1);
    assign w_dm2     = r_depth - DW'(2);
    assign w_full    = (r_depth == DW'(STACK_DEPTH));
    assign w_empty   = (r_depth == '0);
    assign w_bad     = (r_res > MAG_LIMIT) || (r_res < -MAG_LIMIT);
    assign w_prod    = w_rdata * r_top;
    assign w_abs_l   = w_rdata[VAL_W-1] ? VAL_W'(-w_rdata) : w_rdata;
    assign w_abs_r   = r_top[VAL_W-1] ? VAL_W'(-r_top) : r_top;
    assign w_rem_sh  = {r_rem, r_quo[VAL_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};
    assign w_depth_ext = {{DOUT_W{1'b0}}, r_depth};

    always_comb begin
        n_state = r_state;  n_cmd = r_cmd;   n_val = r_val;    n_depth = r_depth;
        n_err   = r_err;    n_top = r_top;   n_left = r_left;  n_res = r_res;
        n_rem   = r_rem;    n_quo = r_quo;   n_dvs = r_dvs;    n_cnt = r_cnt;
        n_neg_q = r_neg_q;  n_neg_l = r_neg_l;
        n_o_valid = r_o_valid; n_o_err = r_o_err; n_o_depth = r_o_depth;
        n_o_top = r_o_top;     n_o_ans = r_o_ans;
        w_we    = 1'b0;
        w_waddr = w_dm1[AW-1:0];
        w_wdata = r_top;
        w_raddr = w_dm1[AW-1:0];

        // drop the held result once taken
        if (!i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_val   = i_operand_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_cmd == CMD_START) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = r_val;
                    n_depth = DW'(1);
                    n_err   = 1'b0;
                    n_top   = r_val;
                end else if (!r_err) begin
                    case (r_cmd)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_err = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_depth[AW-1:0];
                                w_wdata = r_val;
                                n_depth = r_depth + DW'(1);
                                n_top   = r_val;
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_err = 1'b1;
                            end else begin
                                n_depth = w_dm1;
                                n_state = S_TOPRD;
                            end
                        end
                        CMD_NEG: begin
                            if (w_empty) begin
                                n_err = 1'b1;
                            end else begin
                                n_res   = -RES_W'(r_top);
                                n_state = S_CHK;
                            end
                        end
                        CMD_DUP: begin
                            if (w_empty || w_full) begin
                                n_err = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_depth[AW-1:0];
                                w_wdata = r_top;
                                n_depth = r_depth + DW'(1);
                            end
                        end
                        CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                            if (r_depth < DW'(2)) begin
                                n_err = 1'b1;
                            end else begin
                                w_raddr = w_dm2[AW-1:0];
                                n_state = S_LRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LRD: begin
                n_left  = w_rdata;
                n_state = S_CHK;
                case (r_cmd)
                    CMD_SWAP: begin
                        w_we    = 1'b1;
                        w_waddr = w_dm1[AW-1:0];
                        w_wdata = w_rdata;
                        n_state = S_SWP;
                    end
                    CMD_ADD: n_res = RES_W'(w_rdata) + RES_W'(r_top);
                    CMD_SUB: n_res = RES_W'(w_rdata) - RES_W'(r_top);
                    CMD_MUL: n_res = RES_W'(w_prod);
                    default: begin
                        if (r_top == '0) begin
                            n_err   = 1'b1;
                            n_depth = w_dm2;
                            n_state = S_TOPRD;
                        end else begin
                            n_rem   = '0;
                            n_quo   = w_abs_l;
                            n_dvs   = w_abs_r;
                            n_cnt   = '0;
                            n_neg_l = w_rdata[VAL_W-1];
                            n_neg_q = w_rdata[VAL_W-1] ^ r_top[VAL_W-1];
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_SWP: begin
                w_we    = 1'b1;
                w_waddr = w_dm2[AW-1:0];
                w_wdata = r_top;
                n_top   = r_left;
                n_state = S_FIN;
            end
            S_DIV: begin
                // one quotient bit per cycle, restoring
                if (!w_rem_sub[VAL_W]) begin
                    n_rem = w_rem_sub[VAL_W-1:0];
                    n_quo = {r_quo[VAL_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[VAL_W-1:0];
                    n_quo = {r_quo[VAL_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(VAL_W - 1)) begin
                    n_state = S_DFIX;
                end
            end
            S_DFIX: begin
                if (r_cmd == CMD_DIV) begin
                    n_res = r_neg_q ? -RES_W'(r_quo) : RES_W'(r_quo);
                end else begin
                    n_res = r_neg_l ? -RES_W'(r_rem) : RES_W'(r_rem);
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_cmd == CMD_NEG) begin
                    if (w_bad) begin
                        n_err   = 1'b1;
                        n_depth = w_dm1;
                        n_state = S_TOPRD;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_dm1[AW-1:0];
                        w_wdata = r_res[VAL_W-1:0];
                        n_top   = r_res[VAL_W-1:0];
                        n_state = S_FIN;
                    end
                end else begin
                    if (w_bad) begin
                        n_err   = 1'b1;
                        n_depth = w_dm2;
                        n_state = S_TOPRD;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_dm2[AW-1:0];
                        w_wdata = r_res[VAL_W-1:0];
                        n_depth = w_dm1;
                        n_top   = r_res[VAL_W-1:0];
                        n_state = S_FIN;
                    end
                end
            end
            S_TOPRD: begin
                if (w_empty) begin
                    n_top   = '0;
                    n_state = S_FIN;
                end else begin
                    w_raddr = w_dm1[AW-1:0];
                    n_state = S_TOPLD;
                end
            end
            S_TOPLD: begin
                n_top   = w_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_err   = r_err;
                    n_o_depth = w_depth_ext[DOUT_W-1:0];
                    n_o_top   = w_empty ? '0 : r_top;
                    n_o_ans   = !r_err && (r_depth == DW'(1));
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_err     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_err     <= n_err;
            r_o_valid <= n_o_valid;
        end
        r_cmd     <= n_cmd;
        r_val     <= n_val;
        r_top     <= n_top;
        r_left    <= n_left;
        r_res     <= n_res;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_cnt     <= n_cnt;
        r_neg_q   <= n_neg_q;
        r_neg_l   <= n_neg_l;
        r_o_err   <= n_o_err;
        r_o_depth <= n_o_depth;
        r_o_top   <= n_o_top;
        r_o_ans   <= n_o_ans;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_error_seen   = r_o_err;
    assign o_stack_depth  = r_o_depth;
    assign o_top_value    = r_o_top;
    assign o_answer_valid = r_o_ans;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dvs != '0)
        else $error("divider running on a zero divisor");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd == CMD_START) |=> (r_depth == DW'(1) && !r_err))
        else $error("start did not leave a single entry and a clear flag");

    a_err_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_err && r_cmd != CMD_START) |=>
            ($stable(r_depth) && r_state == S_FIN))
        else $error("instruction acted while error flag set");
endmodule

@@ tb/stack_calculator_with_error_checks_unit_test.sv @@
// Testbench for the stack calculator: random and directed instruction beats, scoreboard check.
`timescale 1ns / 100ps

module stack_calculator_with_error_checks_unit_test;
    import scu_pkg::*;

    localparam int DEPTH      = DEF_STACK_DEPTH;
    localparam int CYCLE_CAP  = 1000000;
    localparam longint LIMIT  = 1000000000;

    // Command codes outside the defined set.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd11;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

    // Expected result of one instruction beat.
    typedef struct packed {
        logic                    err;
        logic [DOUT_W-1:0]       depth;
        logic signed [VAL_W-1:0] top;
        logic                    answer;
    } t_calc_result;

    int mismatches = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("error: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Mirror of the stack machine plus the queue of outcomes still to arrive.
    class calc_scoreboard;
        longint       stack_mirror[DEPTH];
        int           depth;
        bit           err;
        t_calc_result pending[$];

        function new();
            depth = 0;
            err = 0;
        endfunction

        function void push_value(longint v);
            if (depth >= DEPTH) err = 1;
            else begin
                stack_mirror[depth] = v;
                depth++;
            end
        endfunction

        function void push_checked(longint v);
            if (v > LIMIT || v < -LIMIT) err = 1;
            else push_value(v);
        endfunction

        function void apply_binary(logic [CMD_W-1:0] cmd);
            longint rhs, lhs;
            if (depth < 2) begin
                err = 1;
                return;
            end
            rhs = stack_mirror[depth-1];
            lhs = stack_mirror[depth-2];
            if (cmd == CMD_SWAP) begin
                stack_mirror[depth-1] = lhs;
                stack_mirror[depth-2] = rhs;
                return;
            end
            depth -= 2;
            case (cmd)
                CMD_ADD: push_checked(lhs + rhs);
                CMD_SUB: push_checked(lhs - rhs);
                CMD_MUL: push_checked(lhs * rhs);
                default: begin
                    if (rhs == 0) err = 1;
                    else if (cmd == CMD_DIV) push_checked(lhs / rhs);
                    else push_checked(lhs % rhs);
                end
            endcase
        endfunction

        // Note an accepted instruction and queue its outcome.
        function void note_instruction(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
            t_calc_result r;
            longint t;
            if (cmd == CMD_START) begin
                depth = 0;
                err = 0;
                push_value(val);
            end else if (!err && cmd <= CMD_MOD) begin
                case (cmd)
                    CMD_PUSH: push_value(val);
                    CMD_POP:  if (depth == 0) err = 1; else depth--;
                    CMD_NEG: begin
                        if (depth == 0) err = 1;
                        else begin
                            t = stack_mirror[depth-1];
                            depth--;
                            push_checked(-t);
                        end
                    end
                    CMD_DUP:  if (depth == 0) err = 1; else push_value(stack_mirror[depth-1]);
                    default:  apply_binary(cmd);
                endcase
            end
            r.err    = err;
            r.depth  = depth[DOUT_W-1:0];
            r.top    = (depth > 0) ? stack_mirror[depth-1][VAL_W-1:0] : '0;
            r.answer = !err && depth == 1;
            pending.push_back(r);
        endfunction

        task check_result(t_calc_result got);
            t_calc_result want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, depth", got.depth, 0);
                return;
            end
            want = pending.pop_front();
            if (got.err !== want.err) report_mismatch("error_seen", got.err, want.err);
            if (got.depth !== want.depth) report_mismatch("stack_depth", got.depth, want.depth);
            if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
            if (got.answer !== want.answer)
                report_mismatch("answer_valid", got.answer, want.answer);
        endtask
    endclass

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    i_valid = 0;
    logic                    o_stall;
    logic [CMD_W-1:0]        i_command = CMD_START;
    logic signed [VAL_W-1:0] i_operand_value = '0;
    logic                    o_valid;
    logic                    i_stall = 0;
    logic                    o_error_seen;
    logic [DOUT_W-1:0]       o_stack_depth;
    logic signed [VAL_W-1:0] o_top_value;
    logic                    o_answer_valid;

    stack_calculator_with_error_checks_unit dut (.*);

    always #5 i_clk = ~i_clk;

    calc_scoreboard board = new();
    int send_idle_pct = 17;
    int recv_idle_pct = 65;
    int cycles = 0;

    // Watchdog: fail the run if it overstays the cap.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("stack_calculator_with_error_checks_unit: mismatch");
            $finish;
        end
    end

    // Receiver: sample accepted result beats at the rising edge.
    always @(posedge i_clk) begin
        t_calc_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.err    = o_error_seen;
            got.depth  = o_stack_depth;
            got.top    = o_top_value;
            got.answer = o_answer_valid;
            board.check_result(got);
        end
    end

    // Receiver stall: redraw at each falling edge; stretches without stall
    // come from the phase where the percentage is zero.
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    // Send one instruction beat: idle at random first, then hold until taken.
    // Valid stays high after the beat; the next beat replaces or lowers it, or the drain lowers it.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input longint val);
        logic signed [VAL_W-1:0] v;
        v = VAL_W'(val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid         <= 1;
        i_command       <= cmd;
        i_operand_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_instruction(cmd, v);
        @(negedge i_clk);
    endtask

    // Operand draw: mostly small values so arithmetic stays in range, with
    // extremes and full-range noise mixed in.
    function automatic longint pick_value();
        case ($urandom_range(9))
            0:       return longint'($urandom);
            1:       return ($urandom_range(1)) ? LIMIT : -LIMIT;
            2:       return 0;
            3, 4:    return longint'($urandom_range(2000000000)) - LIMIT;
            default: return longint'($urandom_range(200)) - 100;
        endcase
    endfunction

    // One well-formed program: start, a run of pushes and operations, and
    // occasionally a random command code that may be unknown or underflow.
    task automatic run_program(output int n);
        int len;
        int d;
        logic [CMD_W-1:0] c;
        len = $urandom_range(3, 14);
        send_beat(CMD_START, pick_value());
        d = 1;
        n = 1;
        repeat (len) begin
            if ($urandom_range(19) == 0) c = CMD_W'($urandom_range(15));
            else if (d < 2 || $urandom_range(2) == 0) c = CMD_PUSH;
            else c = CMD_W'($urandom_range(CMD_POP, CMD_MOD));
            send_beat(c, pick_value());
            d = board.depth;
            n++;
        end
    endtask

    task automatic run_phase(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            run_program(n);
            sent += n;
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int i;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: every command, extremes, errors, recovery via start.
        send_beat(CMD_POP, 0);                    // underflow on empty stack
        send_beat(CMD_PUSH, 5);                   // ignored while flagged
        send_beat(CMD_START, 1000000000);
        send_beat(CMD_PUSH, -1000000000);
        send_beat(CMD_SWAP, 0);
        send_beat(CMD_SUB, 0);                    // magnitude over the limit
        send_beat(CMD_START, -7);
        send_beat(CMD_PUSH, 2);
        send_beat(CMD_DIV, 0);                    // truncates toward zero
        send_beat(CMD_PUSH, 2);
        send_beat(CMD_MOD, 0);
        send_beat(CMD_NEG, 0);
        send_beat(CMD_DUP, 0);
        send_beat(CMD_MUL, 0);
        send_beat(CMD_PUSH, 3);
        send_beat(CMD_ADD, 0);
        send_beat(CMD_UNKNOWN_LO, 0);             // unknown command
        send_beat(CMD_UNKNOWN_HI, {VAL_W{1'b1}});
        send_beat(CMD_PUSH, 0);
        send_beat(CMD_DIV, 0);                    // zero divisor
        send_beat(CMD_START, {1'b1, {(VAL_W-1){1'b0}}}); // out-of-range push
        send_beat(CMD_NEG, 0);
        send_beat(CMD_START, {1'b0, {(VAL_W-1){1'b1}}});
        send_beat(CMD_DUP, 0);
        // Fill the stack to overflow once.
        send_beat(CMD_START, 1);
        for (i = 1; i <= DEPTH; i++) send_beat(CMD_PUSH, i);

        run_phase(235);
        send_idle_pct = 65;
        recv_idle_pct = 17;
        run_phase(235);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(235);

        drain();
        if (mismatches == 0 && board.pending.size() == 0)
            $display("stack_calculator_with_error_checks_unit: match");
        else
            $display("stack_calculator_with_error_checks_unit: mismatch");
        $finish;
    end

endmodule
